FILE: design/lnf_pkg.sv
// Package for the character LCD number formatter: request codes, LCD byte
// constants, the link types between the sequencer and the BCD converter.
// Depends on nothing; every other design file uses it.
`default_nettype none

package lnf_pkg;

  // Field widths of the request and of the emitted bytes.
  localparam int unsigned ActionW = 2;
  localparam int unsigned RowW    = 2;
  localparam int unsigned ColW    = 6;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned CntW    = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned NibW    = 4;

  // Digit limits. The BCD link always carries the widest digit string.
  localparam int unsigned MaxDigitsDef = 5;
  localparam int unsigned MaxDigitsTop = 5;
  localparam int unsigned HexDigitLim  = 4;
  localparam int unsigned BcdW         = MaxDigitsTop * NibW;
  localparam int unsigned BitCntW      = $clog2(ValueW);

  // Request kinds.
  typedef enum logic [ActionW-1:0] {
    ACT_DEC  = 2'd0,
    ACT_HEX  = 2'd1,
    ACT_CHAR = 2'd2,
    ACT_INIT = 2'd3
  } lnf_action_e;

  // Display lines that take a cursor command.
  localparam logic [RowW-1:0] RowOne = 2'd1;
  localparam logic [RowW-1:0] RowTwo = 2'd2;

  // LCD byte constants.
  localparam logic [ByteW-1:0] CursorBase = 8'h80;
  localparam logic [ByteW-1:0] RowTwoOff  = 8'h40;
  localparam logic [ByteW-1:0] AsciiZero  = 8'h30;
  localparam logic [ByteW-1:0] AsciiAlpha = 8'h37;
  localparam logic [ByteW-1:0] InitFunc   = 8'h38;
  localparam logic [ByteW-1:0] InitDisp   = 8'h0C;
  localparam logic [ByteW-1:0] InitEntry  = 8'h06;
  localparam logic [ByteW-1:0] InitHome   = 8'h80;
  localparam logic [CntW-1:0]  InitLen    = 3'd4;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } lnf_state_e;

  // Start of a binary to BCD conversion.
  typedef struct packed {
    logic              start;
    logic [ValueW-1:0] bin;
  } lnf_conv_req_t;

  // Conversion result; digits hold until the next start.
  typedef struct packed {
    logic            done;
    logic [BcdW-1:0] digits;
  } lnf_conv_rsp_t;

  // Init byte for a given number of bytes still to go (4 down to 1).
  function automatic logic [ByteW-1:0] init_byte(input logic [CntW-1:0] left);
    logic [ByteW-1:0] b;
    case (left)
      3'd4:    b = InitFunc;
      3'd3:    b = InitDisp;
      3'd2:    b = InitEntry;
      default: b = InitHome;
    endcase
    return b;
  endfunction

  // Selects one nibble of the digit string, digit 0 being the least significant.
  function automatic logic [NibW-1:0] pick_nibble(input logic [BcdW-1:0] digits,
                                                  input logic [CntW-1:0] idx);
    logic [NibW-1:0] n;
    case (idx)
      3'd0:    n = digits[3:0];
      3'd1:    n = digits[7:4];
      3'd2:    n = digits[11:8];
      3'd3:    n = digits[15:12];
      3'd4:    n = digits[19:16];
      default: n = '0;
    endcase
    return n;
  endfunction

  // ASCII for one digit, uppercase letters above nine.
  function automatic logic [ByteW-1:0] digit_ascii(input logic [NibW-1:0] nib);
    logic [ByteW-1:0] b;
    if (nib < 4'd10) begin
      b = AsciiZero + {4'h0, nib};
    end else begin
      b = AsciiAlpha + {4'h0, nib};
    end
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: design/lnf_bcd_unit.sv
// Shared shift-and-add-3 unit that turns the 16-bit value into BCD digits,
// one bit per cycle. Depends on lnf_pkg.
`default_nettype none

module lnf_bcd_unit #(
  parameter int unsigned NUM_DIGITS = lnf_pkg::MaxDigitsDef
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire lnf_pkg::lnf_conv_req_t conv_req_i,
  output lnf_pkg::lnf_conv_rsp_t      conv_rsp_o
);
  import lnf_pkg::*;

  logic [ValueW-1:0]  bin_q, bin_d;
  logic [BcdW-1:0]    bcd_q, bcd_d;
  logic [BitCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [BcdW-1:0]    lane_mask;
  logic [BcdW-1:0]    adj;

  // Only the configured digit lanes take part; higher lanes stay zero, which
  // leaves the value modulo the digit range.
  always_comb begin
    for (int l = 0; l < int'(MaxDigitsTop); l++) begin
      lane_mask[l*NibW +: NibW] = (l < int'(NUM_DIGITS)) ? 4'hF : 4'h0;
    end
  end

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int l = 0; l < int'(MaxDigitsTop); l++) begin
      if (bcd_q[l*NibW +: NibW] >= 4'd5) begin
        adj[l*NibW +: NibW] = bcd_q[l*NibW +: NibW] + 4'd3;
      end else begin
        adj[l*NibW +: NibW] = bcd_q[l*NibW +: NibW];
      end
    end
  end

  // One step per cycle while busy; a start loads a fresh value.
  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (conv_req_i.start) begin
      bin_d  = conv_req_i.bin;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bin_d = {bin_q[ValueW-2:0], 1'b0};
      bcd_d = {adj[BcdW-2:0], bin_q[ValueW-1]} & lane_mask;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == BitCntW'(ValueW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign conv_rsp_o.done   = done_q;
  assign conv_rsp_o.digits = bcd_q;

endmodule

`default_nettype wire

FILE: design/lnf_seq.sv
// Request sequencer: captures a request, runs the BCD unit for decimal
// numbers and emits the LCD bytes through an output register. Depends on lnf_pkg.
`default_nettype none

module lnf_seq #(
  parameter int unsigned MAX_DIGITS = lnf_pkg::MaxDigitsDef
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire [lnf_pkg::ActionW-1:0]     action_i,
  input  wire [lnf_pkg::RowW-1:0]        row_i,
  input  wire [lnf_pkg::ColW-1:0]        column_i,
  input  wire [lnf_pkg::ValueW-1:0]      value_i,
  input  wire [lnf_pkg::CntW-1:0]        digit_count_i,
  input  wire [lnf_pkg::ByteW-1:0]       glyph_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [lnf_pkg::ByteW-1:0]      lcd_byte_o,
  output logic                           is_data_o,
  output logic                           last_o,
  output lnf_pkg::lnf_conv_req_t         conv_req_o,
  input  wire lnf_pkg::lnf_conv_rsp_t    conv_rsp_i
);
  import lnf_pkg::*;

  lnf_state_e        state_q, state_d;
  lnf_action_e       mode_q, mode_d;
  lnf_action_e       act_in;
  logic              cur_pend_q, cur_pend_d;
  logic [ByteW-1:0]  cur_byte_q, cur_byte_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic [ByteW-1:0]  glyph_q, glyph_d;
  logic [ValueW-1:0] value_q, value_d;
  logic              oval_q, oval_d;
  logic [ByteW-1:0]  obyte_q, obyte_d;
  logic              odata_q, odata_d;
  logic              olast_q, olast_d;
  logic              accept;
  logic              slot_free;
  logic [CntW-1:0]   dec_cnt;
  logic [CntW-1:0]   hex_cnt;
  logic [ByteW-1:0]  row_off;
  logic [BcdW-1:0]   digits;
  logic [CntW-1:0]   rem_dec;

  assign act_in    = lnf_action_e'(action_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !oval_q || out_ready_i;
  assign rem_dec   = rem_q - 1'b1;

  // Digit counts clamped per mode.
  assign dec_cnt = (digit_count_i > CntW'(MAX_DIGITS)) ? CntW'(MAX_DIGITS) : digit_count_i;
  assign hex_cnt = (digit_count_i > CntW'(HexDigitLim)) ? CntW'(HexDigitLim) : digit_count_i;
  assign row_off = (row_i == RowTwo) ? RowTwoOff : '0;

  // Hex digits come straight from the value, decimal ones from the BCD unit.
  assign digits = (mode_q == ACT_HEX) ? {{(BcdW - ValueW){1'b0}}, value_q}
                                      : conv_rsp_i.digits;

  assign conv_req_o.start = accept && (act_in == ACT_DEC);
  assign conv_req_o.bin   = value_i;

  // Next state and byte emission.
  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    cur_pend_d = cur_pend_q;
    cur_byte_d = cur_byte_q;
    rem_d      = rem_q;
    glyph_d    = glyph_q;
    value_d    = value_q;
    oval_d     = oval_q && !out_ready_i;
    obyte_d    = obyte_q;
    odata_d    = odata_q;
    olast_d    = olast_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d     = act_in;
          glyph_d    = glyph_i;
          value_d    = value_i;
          cur_byte_d = CursorBase + row_off + {2'b00, column_i} - 8'd1;
          cur_pend_d = (act_in != ACT_INIT) && ((row_i == RowOne) || (row_i == RowTwo));
          case (act_in)
            ACT_DEC:  rem_d = dec_cnt;
            ACT_HEX:  rem_d = hex_cnt;
            ACT_CHAR: rem_d = 3'd1;
            ACT_INIT: rem_d = InitLen;
            default:  rem_d = '0;
          endcase
          state_d = (act_in == ACT_DEC) ? ST_CONV : ST_EMIT;
        end
      end
      ST_CONV: begin
        if (conv_rsp_i.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!cur_pend_q && (rem_q == '0)) begin
          // A request with nothing to print ends here.
          state_d = ST_IDLE;
        end else if (slot_free) begin
          oval_d = 1'b1;
          if (cur_pend_q) begin
            obyte_d    = cur_byte_q;
            odata_d    = 1'b0;
            olast_d    = (rem_q == '0);
            cur_pend_d = 1'b0;
          end else begin
            olast_d = (rem_q == 3'd1);
            rem_d   = rem_dec;
            case (mode_q)
              ACT_INIT: begin
                obyte_d = init_byte(rem_q);
                odata_d = 1'b0;
              end
              ACT_CHAR: begin
                obyte_d = glyph_q;
                odata_d = 1'b1;
              end
              default: begin
                obyte_d = digit_ascii(pick_nibble(digits, rem_dec));
                odata_d = 1'b1;
              end
            endcase
          end
          if (olast_d) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cur_pend_q <= 1'b0;
      rem_q      <= '0;
      oval_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_pend_q <= cur_pend_d;
      rem_q      <= rem_d;
      oval_q     <= oval_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    cur_byte_q <= cur_byte_d;
    glyph_q    <= glyph_d;
    value_q    <= value_d;
    obyte_q    <= obyte_d;
    odata_q    <= odata_d;
    olast_q    <= olast_d;
  end

  assign out_valid_o = oval_q;
  assign lcd_byte_o  = obyte_q;
  assign is_data_o   = odata_q;
  assign last_o      = olast_q;

endmodule

`default_nettype wire

FILE: design/lcd_number_text_formatter.sv
// Top level of the character LCD number formatter: the request sequencer
// and the shared BCD converter. Depends on lnf_pkg, lnf_seq, lnf_bcd_unit.
//
//   Channel   Direction  Handshake              Carries
//   in        input      in_valid_i/in_ready_o  action, row, column, value,
//                                               digit_count, glyph
//   out       output     out_valid_o/out_ready_i lcd_byte, is_data, last
//
// One request at a time: in_ready_o is high only while the sequencer is idle.
// A decimal request first runs through the BCD unit (one value bit a cycle),
// then one byte per cycle is emitted while the output is not stalled; all
// requests emit at most six bytes.
// A stalled output holds the sequencer; the last byte of a request may wait
// in the output register while the next request is taken.
// Reset clears the control state only; there is no stored table to clear.
`default_nettype none

module lcd_number_text_formatter #(
  parameter int unsigned MAX_DIGITS = lnf_pkg::MaxDigitsDef
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire [lnf_pkg::ActionW-1:0] action_i,
  input  wire [lnf_pkg::RowW-1:0]    row_i,
  input  wire [lnf_pkg::ColW-1:0]    column_i,
  input  wire [lnf_pkg::ValueW-1:0]  value_i,
  input  wire [lnf_pkg::CntW-1:0]    digit_count_i,
  input  wire [lnf_pkg::ByteW-1:0]   glyph_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [lnf_pkg::ByteW-1:0]  lcd_byte_o,
  output logic                       is_data_o,
  output logic                       last_o
);
  import lnf_pkg::*;

  lnf_conv_req_t conv_req;
  lnf_conv_rsp_t conv_rsp;

  // Request sequencer with the output register.
  lnf_seq #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .value_i      (value_i),
    .digit_count_i(digit_count_i),
    .glyph_i      (glyph_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .lcd_byte_o   (lcd_byte_o),
    .is_data_o    (is_data_o),
    .last_o       (last_o),
    .conv_req_o   (conv_req),
    .conv_rsp_i   (conv_rsp)
  );

  // Shared binary to BCD unit.
  lnf_bcd_unit #(
    .NUM_DIGITS(MAX_DIGITS)
  ) u_bcd (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .conv_req_i(conv_req),
    .conv_rsp_o(conv_rsp)
  );

endmodule

`default_nettype wire

FILE: design/lnf_checker.sv
// Port-level checks for the character LCD number formatter, bound to the
// top level. Depends on lnf_pkg and lcd_number_text_formatter.
`default_nettype none

module lnf_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        in_valid_i,
  input wire                        in_ready_o,
  input wire                        out_valid_o,
  input wire                        out_ready_i,
  input wire [lnf_pkg::ByteW-1:0]   lcd_byte_o,
  input wire                        is_data_o,
  input wire                        last_o
);

  // A stalled output byte holds its value and tags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(lcd_byte_o)
      && $stable(is_data_o) && $stable(last_o))
    else $error("output request changed while stalled");

  // After a request is taken the block is busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  // While a byte that is not the last waits, no new request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("ready while a request is still being emitted");

  // When ready, any waiting byte closes the previous request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> last_o)
    else $error("ready with a pending byte that is not the last");

endmodule

bind lcd_number_text_formatter lnf_checker u_lnf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .lcd_byte_o (lcd_byte_o),
  .is_data_o  (is_data_o),
  .last_o     (last_o)
);

`default_nettype wire

FILE: verif/tb_lcd_number_text_formatter.sv
// Testbench for lcd_number_text_formatter: checks every LCD byte against a
// cycle-free predictor of the formatter under random handshake stalls.
// Depends on lnf_pkg and the formatter RTL.
`timescale 1ns / 100ps

module tb_lcd_number_text_formatter;
  import lnf_pkg::*;

  localparam int unsigned DecDigitMax = MaxDigitsDef;
  localparam int unsigned RandomReqs  = 350;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned CycleLimit  = 800000;

  // One display request as it appears on the input ports.
  typedef struct {
    lnf_action_e       action;
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   column;
    logic [ValueW-1:0] value;
    logic [CntW-1:0]   digit_count;
    logic [ByteW-1:0]  glyph;
  } lcd_req_t;

  // One byte bound for the LCD bus.
  typedef struct {
    logic [ByteW-1:0] lcd_byte;
    logic             is_data;
    logic             last;
  } lcd_byte_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  lnf_action_e       action_i;
  logic [RowW-1:0]   row_i;
  logic [ColW-1:0]   column_i;
  logic [ValueW-1:0] value_i;
  logic [CntW-1:0]   digit_count_i;
  logic [ByteW-1:0]  glyph_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [ByteW-1:0]  lcd_byte_o;
  logic              is_data_o;
  logic              last_o;

  lcd_req_t  pending_reqs[$];
  lcd_byte_t expected_lcd_bytes[$];

  int  errors        = 0;
  int  reqs_accepted = 0;
  int  bytes_checked = 0;
  int  action_seen[4];
  int  cycle_cnt     = 0;
  int  req_gap_left  = 0;
  int  stall_left    = 0;
  bit  req_taken     = 1'b0;
  bit  quiet_phase   = 1'b0;

  lcd_number_text_formatter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .row_i         (row_i),
    .column_i      (column_i),
    .value_i       (value_i),
    .digit_count_i (digit_count_i),
    .glyph_i       (glyph_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .lcd_byte_o    (lcd_byte_o),
    .is_data_o     (is_data_o),
    .last_o        (last_o)
  );

  // Free-running clock, 8 ns period.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Idle length: mostly short, now and then long, none in a quiet phase.
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Appends the cursor command for lines one and two; other lines get none.
  function automatic void push_cursor(logic [RowW-1:0] row, logic [ColW-1:0] column);
    lcd_byte_t b;
    b.is_data = 1'b0;
    b.last    = 1'b0;
    if (row == RowOne) begin
      b.lcd_byte = CursorBase + {2'b00, column} - 8'd1;
      expected_lcd_bytes.push_back(b);
    end else if (row == RowTwo) begin
      b.lcd_byte = CursorBase + RowTwoOff + {2'b00, column} - 8'd1;
      expected_lcd_bytes.push_back(b);
    end
  endfunction

  // Predicts the byte sequence of one accepted request and queues it.
  function automatic void format_lcd_request(lcd_req_t r);
    lcd_byte_t   b;
    int          first_idx;
    int unsigned ndig;
    int unsigned weight;
    int unsigned digit;
    first_idx = expected_lcd_bytes.size();
    b.last    = 1'b0;
    b.is_data = 1'b1;
    case (r.action)
      ACT_INIT: begin
        b.is_data = 1'b0;
        b.lcd_byte = InitFunc;
        expected_lcd_bytes.push_back(b);
        b.lcd_byte = InitDisp;
        expected_lcd_bytes.push_back(b);
        b.lcd_byte = InitEntry;
        expected_lcd_bytes.push_back(b);
        b.lcd_byte = InitHome;
        expected_lcd_bytes.push_back(b);
      end
      ACT_CHAR: begin
        push_cursor(r.row, r.column);
        b.lcd_byte = r.glyph;
        expected_lcd_bytes.push_back(b);
      end
      ACT_DEC: begin
        ndig = (r.digit_count > DecDigitMax) ? DecDigitMax : r.digit_count;
        push_cursor(r.row, r.column);
        for (int i = ndig; i > 0; i--) begin
          weight = 1;
          for (int k = 1; k < i; k++) weight = weight * 10;
          digit = (r.value / weight) % 10;
          b.lcd_byte = AsciiZero + digit[7:0];
          expected_lcd_bytes.push_back(b);
        end
      end
      default: begin
        ndig = (r.digit_count > HexDigitLim) ? HexDigitLim : r.digit_count;
        push_cursor(r.row, r.column);
        for (int i = ndig; i > 0; i--) begin
          digit = (r.value >> (4 * (i - 1))) & 32'hF;
          b.lcd_byte = (digit < 10) ? AsciiZero + digit[7:0] : AsciiAlpha + digit[7:0];
          expected_lcd_bytes.push_back(b);
        end
      end
    endcase
    // The final byte of a request carries the last flag.
    if (expected_lcd_bytes.size() > first_idx) begin
      expected_lcd_bytes[expected_lcd_bytes.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void add_request(lnf_action_e action, logic [RowW-1:0] row,
                                      logic [ColW-1:0] column, logic [ValueW-1:0] value,
                                      logic [CntW-1:0] digit_count, logic [ByteW-1:0] glyph);
    lcd_req_t r;
    r.action      = action;
    r.row         = row;
    r.column      = column;
    r.value       = value;
    r.digit_count = digit_count;
    r.glyph       = glyph;
    pending_reqs.push_back(r);
  endfunction

  // Request driver: holds a request until it is accepted, then idles a while.
  always @(negedge clk_i) begin
    lcd_req_t r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !req_taken)) begin
      req_taken = 1'b0;
      if (req_gap_left > 0) begin
        in_valid_i <= 1'b0;
        req_gap_left--;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        action_i      <= r.action;
        row_i         <= r.row;
        column_i      <= r.column;
        value_i       <= r.value;
        digit_count_i <= r.digit_count;
        glyph_i       <= r.glyph;
        in_valid_i    <= 1'b1;
        req_gap_left  = pick_idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output back-pressure: random stalls of random length.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 99) < 25) stall_left = pick_idle_len();
    end
  end

  // Monitor: checks emitted bytes first, then records a newly accepted request.
  always @(posedge clk_i) begin
    lcd_req_t  r;
    lcd_byte_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_lcd_bytes.size() == 0) begin
          $display("%0t: unexpected LCD byte %h is_data %b last %b", $time,
                   lcd_byte_o, is_data_o, last_o);
          errors++;
        end else begin
          e = expected_lcd_bytes.pop_front();
          if (lcd_byte_o !== e.lcd_byte || is_data_o !== e.is_data || last_o !== e.last) begin
            $display("%0t: mismatch, expected byte %h is_data %b last %b, got %h %b %b",
                     $time, e.lcd_byte, e.is_data, e.last, lcd_byte_o, is_data_o, last_o);
            errors++;
          end
          bytes_checked++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        r.action      = action_i;
        r.row         = row_i;
        r.column      = column_i;
        r.value       = value_i;
        r.digit_count = digit_count_i;
        r.glyph       = glyph_i;
        format_lcd_request(r);
        action_seen[r.action]++;
        reqs_accepted++;
        req_taken = 1'b1;
        // Switch between idling and back-to-back stretches now and then.
        if ($urandom_range(0, 29) == 0) quiet_phase = !quiet_phase;
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout with %0d bytes outstanding", $time, expected_lcd_bytes.size());
      $display("[lcd_number_text_formatter] ERROR");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    lcd_req_t r;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    out_ready_i   = 1'b0;
    action_i      = ACT_DEC;
    row_i         = '0;
    column_i      = '0;
    value_i       = '0;
    digit_count_i = '0;
    glyph_i       = '0;
    for (int a = 0; a < 4; a++) action_seen[a] = 0;

    // Directed requests: every mode, field extremes and the corner cases.
    add_request(ACT_INIT, 2'd0, 6'd0, 16'h0000, 3'd0, 8'h00);
    add_request(ACT_CHAR, RowOne, 6'd1, 16'hFFFF, 3'd7, 8'h00);
    add_request(ACT_CHAR, RowTwo, 6'd40, 16'h0000, 3'd0, 8'hFF);
    add_request(ACT_CHAR, 2'd0, 6'd5, 16'h1234, 3'd3, 8'h41);
    add_request(ACT_CHAR, 2'd3, 6'd63, 16'h8000, 3'd5, 8'h7E);
    // Column zero and columns past the line wrap the cursor byte.
    add_request(ACT_CHAR, RowOne, 6'd0, 16'h0000, 3'd0, 8'h30);
    add_request(ACT_CHAR, RowTwo, 6'd0, 16'h0000, 3'd0, 8'h31);
    add_request(ACT_CHAR, RowOne, 6'd63, 16'h0000, 3'd0, 8'h80);
    add_request(ACT_CHAR, RowTwo, 6'd63, 16'h0000, 3'd0, 8'h55);
    add_request(ACT_DEC, RowOne, 6'd1, 16'hFFFF, 3'd5, 8'hAA);
    add_request(ACT_DEC, RowTwo, 6'd16, 16'h0000, 3'd5, 8'h00);
    add_request(ACT_DEC, RowOne, 6'd7, 16'd12345, 3'd7, 8'h00);
    add_request(ACT_DEC, RowTwo, 6'd2, 16'd54321, 3'd6, 8'h00);
    add_request(ACT_DEC, RowOne, 6'd3, 16'hFFFF, 3'd3, 8'h00);
    add_request(ACT_DEC, RowOne, 6'd9, 16'd42, 3'd0, 8'h00);
    // Neither a cursor nor digits: the request yields nothing.
    add_request(ACT_DEC, 2'd0, 6'd9, 16'd9, 3'd0, 8'h00);
    add_request(ACT_DEC, 2'd3, 6'd1, 16'd907, 3'd4, 8'h00);
    add_request(ACT_HEX, RowOne, 6'd1, 16'hFFFF, 3'd4, 8'h00);
    add_request(ACT_HEX, RowTwo, 6'd40, 16'hABCD, 3'd7, 8'h00);
    add_request(ACT_HEX, RowOne, 6'd12, 16'h0000, 3'd5, 8'h00);
    add_request(ACT_HEX, 2'd0, 6'd4, 16'h1234, 3'd1, 8'h00);
    add_request(ACT_HEX, 2'd3, 6'd4, 16'h9EF0, 3'd0, 8'h00);
    add_request(ACT_HEX, RowTwo, 6'd33, 16'h5A6B, 3'd2, 8'h00);
    add_request(ACT_INIT, 2'd3, 6'd63, 16'hFFFF, 3'd7, 8'hFF);

    // Random requests, mostly with a cursor and an on-screen column.
    for (int n = 0; n < RandomReqs; n++) begin
      r.action = lnf_action_e'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 7) r.row = RowW'($urandom_range(1, 2));
      else r.row = RowW'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 85) r.column = ColW'($urandom_range(1, 40));
      else r.column = ColW'($urandom_range(0, 63));
      case ($urandom_range(0, 7))
        0:       r.value = '0;
        1:       r.value = '1;
        default: r.value = ValueW'($urandom_range(0, 65535));
      endcase
      r.digit_count = CntW'($urandom_range(0, 7));
      r.glyph       = ByteW'($urandom_range(0, 255));
      pending_reqs.push_back(r);
    end

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every request is in and every byte is out, then watch a while.
    while (pending_reqs.size() > 0 || in_valid_i || expected_lcd_bytes.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d requests (dec %0d, hex %0d, char %0d, init %0d), %0d LCD bytes.",
             reqs_accepted, action_seen[ACT_DEC], action_seen[ACT_HEX],
             action_seen[ACT_CHAR], action_seen[ACT_INIT], bytes_checked);
    if (errors == 0) begin
      $display("[lcd_number_text_formatter] OK");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("[lcd_number_text_formatter] ERROR");
    end
    $finish;
  end

endmodule
